// ===== hw/rtl/tes_pkg.sv =====
// shared types, constants and codes of the thermal erosion stencil
package tes_pkg;

  // default store dimensions
  localparam int MAX_COLS_DEF = 256;
  localparam int MAX_ROWS_DEF = 256;

  // field widths
  localparam int H_W     = 24;
  localparam int HARD_W  = 8;
  localparam int COORD_W = 8;
  localparam int RATE_W  = 16;
  localparam int GRID_W  = 9;
  localparam int MEM_W   = H_W + HARD_W;

  localparam logic [H_W-1:0] HEIGHT_MAX = {H_W{1'b1}};

  // slide arithmetic: factor numerator 1275 - 4*hardness over 1275
  localparam int FACTOR_W = 11;
  localparam logic [FACTOR_W-1:0] FACTOR_DEN = 11'd1275;
  localparam int P1_W = H_W + RATE_W;
  localparam int P2_W = P1_W + FACTOR_W;
  localparam int X_W  = P2_W - 16;
  // reciprocal of 1275 scaled by 2^35, estimate is low by at most one
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 35;
  localparam logic [RECIP_W-1:0] RECIP_M = 25'd26948814;
  localparam int Q_W   = X_W + RECIP_W - RECIP_SHIFT;
  localparam int ACC_W = H_W + 4;

  // neighborhood walk: index 0 is the cell itself, 1..8 the neighbors
  localparam int NBR_N = 8;
  localparam logic [3:0] LAST_IDX = 4'd8;

  localparam int QUEUE_DEPTH = 2;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // register map
  localparam int APB_ADDR_W = 4;
  typedef enum logic [1:0] {
    REG_GRID_WIDTH,
    REG_GRID_HEIGHT,
    REG_TALUS,
    REG_TRANSFER_RATE
  } tes_reg_t;

  localparam logic [GRID_W-1:0] GRID_WIDTH_RST    = 9'd256;
  localparam logic [GRID_W-1:0] GRID_HEIGHT_RST   = 9'd256;
  localparam logic [H_W-1:0]    TALUS_RST         = 24'd256;
  localparam logic [RATE_W-1:0] TRANSFER_RATE_RST = 16'd8192;

  // classified command as it waits in the queue
  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [H_W-1:0]     height;
    logic [HARD_W-1:0]  hardness;
    logic               oog;
    logic [NBR_N-1:0]   nbr;
  } tes_entry_t;

  // token travelling with a slide computation
  typedef struct packed {
    logic go;
    logic last;
  } tes_tag_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_DRAIN,
    BK_DONE
  } tes_back_state_t;

endpackage

// ===== hw/rtl/tes_channels.sv =====
// command and result channel interfaces

interface tes_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [tes_pkg::COORD_W-1:0] col;
  logic [tes_pkg::COORD_W-1:0] row;
  logic [tes_pkg::H_W-1:0]     cell_height;
  logic [tes_pkg::HARD_W-1:0]  cell_hardness;

  modport source (output valid, command, col, row, cell_height, cell_hardness, input ready);
  modport sink (input valid, command, col, row, cell_height, cell_hardness, output ready);
endinterface

interface tes_out_if;
  logic                    valid;
  logic                    ready;
  logic [tes_pkg::H_W-1:0] eroded_height;
  logic                    out_of_grid;

  modport source (output valid, eroded_height, out_of_grid, input ready);
  modport sink (input valid, eroded_height, out_of_grid, output ready);
endinterface

// ===== hw/rtl/tes_ram.sv =====
// generic single write, single read ram with registered read
module tes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/tes_queue.sv =====
// short queue of classified commands between front and back
module tes_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tes_pkg::tes_entry_t wdata,
  output logic                full,
  output logic                valid,
  output tes_pkg::tes_entry_t head,
  input  logic                pop
);

  localparam int DEPTH = tes_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  tes_pkg::tes_entry_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/tes_front.sv =====
// command intake: grid check, neighbor mask and queue push
module tes_front #(
  parameter int MAX_COLS = tes_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tes_pkg::MAX_ROWS_DEF
) (
  tes_in_if.sink                     cmd_in,
  input  logic [tes_pkg::GRID_W-1:0] grid_width,
  input  logic [tes_pkg::GRID_W-1:0] grid_height,
  input  logic                       full,
  output logic                       push,
  output tes_pkg::tes_entry_t        entry
);

  localparam int CEW = ($clog2(MAX_COLS + 1) > 9) ? $clog2(MAX_COLS + 1) : 9;
  localparam int REW = ($clog2(MAX_ROWS + 1) > 9) ? $clog2(MAX_ROWS + 1) : 9;

  logic [CEW-1:0] w_eff;
  logic [REW-1:0] h_eff;
  logic [CEW-1:0] col_x;
  logic [REW-1:0] row_x;
  logic           in_store;
  logic           left_ok;
  logic           right_ok;
  logic           up_ok;
  logic           down_ok;

  // effective grid size, clamped to 1..max
  always_comb begin
    w_eff = CEW'(grid_width);
    if (w_eff == '0) begin
      w_eff = CEW'(1);
    end else if (w_eff > CEW'(MAX_COLS)) begin
      w_eff = CEW'(MAX_COLS);
    end
    h_eff = REW'(grid_height);
    if (h_eff == '0) begin
      h_eff = REW'(1);
    end else if (h_eff > REW'(MAX_ROWS)) begin
      h_eff = REW'(MAX_ROWS);
    end
  end

  // neighbor presence at the grid edges
  assign col_x    = CEW'(cmd_in.col);
  assign row_x    = REW'(cmd_in.row);
  assign in_store = (32'(cmd_in.col) < 32'(MAX_COLS)) && (32'(cmd_in.row) < 32'(MAX_ROWS));
  assign left_ok  = (col_x != '0);
  assign right_ok = ((col_x + 1'b1) < w_eff);
  assign up_ok    = (row_x != '0);
  assign down_ok  = ((row_x + 1'b1) < h_eff);

  // classified entry, mask in walk order
  always_comb begin
    entry.cmd      = cmd_in.command;
    entry.col      = cmd_in.col;
    entry.row      = cmd_in.row;
    entry.height   = cmd_in.cell_height;
    entry.hardness = cmd_in.cell_hardness;
    entry.oog      = (col_x >= w_eff) || (row_x >= h_eff);
    entry.nbr[0]   = up_ok && left_ok;
    entry.nbr[1]   = up_ok;
    entry.nbr[2]   = up_ok && right_ok;
    entry.nbr[3]   = left_ok;
    entry.nbr[4]   = right_ok;
    entry.nbr[5]   = down_ok && left_ok;
    entry.nbr[6]   = down_ok;
    entry.nbr[7]   = down_ok && right_ok;
  end

  // writes outside the store are dropped here
  assign cmd_in.ready = !full;
  assign push = cmd_in.valid && !full && ((cmd_in.command == tes_pkg::CMD_READ) || in_store);

endmodule

// ===== hw/rtl/tes_slide.sv =====
// five-stage pipeline for one talus slide amount
module tes_slide (
  input  logic                       clk,
  input  logic                       rst,
  input  tes_pkg::tes_tag_t          in_tag,
  input  logic                       use_nbr,
  input  logic [tes_pkg::H_W-1:0]    hi,
  input  logic [tes_pkg::H_W-1:0]    lo,
  input  logic [tes_pkg::HARD_W-1:0] hard,
  input  logic [tes_pkg::H_W-1:0]    talus,
  input  logic [tes_pkg::RATE_W-1:0] rate,
  output tes_pkg::tes_tag_t          out_tag,
  output logic [tes_pkg::H_W-1:0]    amount
);

  localparam int X_W = tes_pkg::X_W;
  localparam int Q_W = tes_pkg::Q_W;

  tes_pkg::tes_tag_t tag [5];

  logic [tes_pkg::H_W-1:0]      drop;
  logic [tes_pkg::H_W-1:0]      excess;
  logic [tes_pkg::FACTOR_W-1:0] factor;
  logic [tes_pkg::FACTOR_W-1:0] factor2;
  logic [tes_pkg::P1_W-1:0]     p1;
  logic [tes_pkg::FACTOR_W-1:0] factor3;
  logic [tes_pkg::P2_W-1:0]     p2;
  logic [X_W-1:0]               x4;
  logic [X_W+tes_pkg::RECIP_W-1:0] est_prod;
  logic [Q_W-1:0]               q_est;
  logic [X_W-1:0]               rem;
  logic [Q_W-1:0]               q_fix;
  logic [tes_pkg::H_W-1:0]      amount_r;

  // tokens
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) begin
        tag[i] <= '0;
      end
    end else begin
      tag[0] <= in_tag;
      for (int i = 1; i < 5; i++) begin
        tag[i] <= tag[i-1];
      end
    end
  end

  // stage 1: excess over talus and factor numerator
  assign drop = hi - lo;
  always_ff @(posedge clk) begin
    excess <= (use_nbr && (hi > lo) && (drop > talus)) ? drop - talus : '0;
    factor <= tes_pkg::FACTOR_DEN - tes_pkg::FACTOR_W'({hard, 2'b00});
  end

  // stage 2: times transfer rate
  always_ff @(posedge clk) begin
    p1      <= tes_pkg::P1_W'(excess) * tes_pkg::P1_W'(rate);
    factor2 <= factor;
  end

  // stage 3: times factor numerator
  always_ff @(posedge clk) begin
    p2      <= tes_pkg::P2_W'(p1) * tes_pkg::P2_W'(factor2);
    factor3 <= factor2;
  end

  // stage 4: drop the q0.16 scale, quotient estimate by reciprocal
  assign est_prod = (X_W + tes_pkg::RECIP_W)'(p2[tes_pkg::P2_W-1:16]) *
                    (X_W + tes_pkg::RECIP_W)'(tes_pkg::RECIP_M);
  always_ff @(posedge clk) begin
    x4    <= p2[tes_pkg::P2_W-1:16];
    q_est <= est_prod[X_W+tes_pkg::RECIP_W-1:tes_pkg::RECIP_SHIFT];
  end

  // stage 5: one correction step
  assign rem   = x4 - X_W'(q_est) * X_W'(tes_pkg::FACTOR_DEN);
  assign q_fix = (rem >= X_W'(tes_pkg::FACTOR_DEN)) ? q_est + 1'b1 : q_est;
  always_ff @(posedge clk) begin
    amount_r <= q_fix[tes_pkg::H_W-1:0];
  end

  assign out_tag = tag[4];
  assign amount  = amount_r;

endmodule

// ===== hw/rtl/tes_back.sv =====
// command execution: cell store, neighborhood walk, slide sums, result register
module tes_back #(
  parameter int MAX_COLS = tes_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tes_pkg::MAX_ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  tes_pkg::tes_entry_t        head,
  output logic                       pop,
  input  logic [tes_pkg::H_W-1:0]    talus,
  input  logic [tes_pkg::RATE_W-1:0] transfer_rate,
  tes_out_if.source                  res_out
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int ACC_W = tes_pkg::ACC_W;

  tes_pkg::tes_back_state_t state, state_next;

  logic [3:0]              idx;
  logic                    start;
  logic                    load_oog;
  logic                    load_res;
  logic                    free;
  logic                    ram_we;
  logic                    ram_re;
  logic [AW-1:0]           base;
  logic [AW-1:0]           vert;
  logic [AW-1:0]           raddr;
  logic [tes_pkg::MEM_W-1:0] rdata;
  logic                    rd_go;
  logic [3:0]              rd_idx;
  logic                    rd_use;
  logic [tes_pkg::H_W-1:0]    self_h;
  logic [tes_pkg::HARD_W-1:0] self_hard;
  logic [tes_pkg::H_W-1:0]    nh;
  logic [tes_pkg::HARD_W-1:0] nhard;
  tes_pkg::tes_tag_t       feed_tag;
  tes_pkg::tes_tag_t       loss_tag;
  tes_pkg::tes_tag_t       gain_tag;
  logic [tes_pkg::H_W-1:0] loss_amt;
  logic [tes_pkg::H_W-1:0] gain_amt;
  logic [ACC_W-1:0]        loss_acc;
  logic [ACC_W-1:0]        gain_acc;
  logic [ACC_W-1:0]        total;
  logic [ACC_W-1:0]        diff;
  logic [tes_pkg::H_W-1:0] res;
  logic                    out_valid;
  logic [tes_pkg::H_W-1:0] out_height;
  logic                    out_oog;

  // addresses of the cell and of the walk position
  assign base = AW'(head.row) * AW'(MAX_COLS) + AW'(head.col);
  always_comb begin
    if (idx inside {4'd1, 4'd2, 4'd3}) begin
      vert = base - AW'(MAX_COLS);
    end else if (idx inside {4'd6, 4'd7, 4'd8}) begin
      vert = base + AW'(MAX_COLS);
    end else begin
      vert = base;
    end
    if (idx inside {4'd1, 4'd4, 4'd6}) begin
      raddr = vert - 1'b1;
    end else if (idx inside {4'd3, 4'd5, 4'd8}) begin
      raddr = vert + 1'b1;
    end else begin
      raddr = vert;
    end
  end

  tes_ram #(
    .WIDTH (tes_pkg::MEM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (base),
    .wdata ({head.hardness, head.height}),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign free = !out_valid || res_out.ready;

  // sequencer next state
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    start      = 1'b0;
    load_oog   = 1'b0;
    load_res   = 1'b0;
    case (state)
      tes_pkg::BK_IDLE: begin
        if (q_valid) begin
          if (head.cmd == tes_pkg::CMD_WRITE) begin
            ram_we = 1'b1;
            pop    = 1'b1;
          end else if (head.oog) begin
            if (free) begin
              load_oog = 1'b1;
              pop      = 1'b1;
            end
          end else begin
            start      = 1'b1;
            state_next = tes_pkg::BK_FETCH;
          end
        end
      end
      tes_pkg::BK_FETCH: begin
        ram_re = 1'b1;
        if (idx == tes_pkg::LAST_IDX) begin
          state_next = tes_pkg::BK_DRAIN;
        end
      end
      tes_pkg::BK_DRAIN: begin
        if (loss_tag.go && loss_tag.last) begin
          state_next = tes_pkg::BK_DONE;
        end
      end
      tes_pkg::BK_DONE: begin
        if (free) begin
          load_res   = 1'b1;
          pop        = 1'b1;
          state_next = tes_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = tes_pkg::BK_IDLE;
      end
    endcase
  end

  // state, walk counter and read tag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tes_pkg::BK_IDLE;
      idx   <= '0;
      rd_go <= 1'b0;
    end else begin
      state <= state_next;
      if (start) begin
        idx <= '0;
      end else if (ram_re) begin
        idx <= idx + 1'b1;
      end
      rd_go <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_idx <= idx;
      rd_use <= (idx != '0) && head.nbr[3'(idx - 4'd1)];
    end
  end

  // the cell itself comes back first
  assign nh    = rdata[tes_pkg::H_W-1:0];
  assign nhard = rdata[tes_pkg::MEM_W-1:tes_pkg::H_W];
  always_ff @(posedge clk) begin
    if (rd_go && (rd_idx == '0)) begin
      self_h    <= nh;
      self_hard <= nhard;
    end
  end

  assign feed_tag.go   = rd_go && (rd_idx != '0);
  assign feed_tag.last = (rd_idx == tes_pkg::LAST_IDX);

  // material the cell gives to a neighbor
  tes_slide u_loss (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (feed_tag),
    .use_nbr (rd_use),
    .hi      (self_h),
    .lo      (nh),
    .hard    (self_hard),
    .talus   (talus),
    .rate    (transfer_rate),
    .out_tag (loss_tag),
    .amount  (loss_amt)
  );

  // material a neighbor gives to the cell
  tes_slide u_gain (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (feed_tag),
    .use_nbr (rd_use),
    .hi      (nh),
    .lo      (self_h),
    .hard    (nhard),
    .talus   (talus),
    .rate    (transfer_rate),
    .out_tag (gain_tag),
    .amount  (gain_amt)
  );

  // slide sums
  always_ff @(posedge clk) begin
    if (start) begin
      loss_acc <= '0;
      gain_acc <= '0;
    end else begin
      if (loss_tag.go) begin
        loss_acc <= loss_acc + ACC_W'(loss_amt);
      end
      if (gain_tag.go) begin
        gain_acc <= gain_acc + ACC_W'(gain_amt);
      end
    end
  end

  // clamp at zero, saturate at full scale
  assign total = ACC_W'(self_h) + gain_acc;
  assign diff  = total - loss_acc;
  always_comb begin
    if (total <= loss_acc) begin
      res = '0;
    end else if (diff > ACC_W'(tes_pkg::HEIGHT_MAX)) begin
      res = tes_pkg::HEIGHT_MAX;
    end else begin
      res = diff[tes_pkg::H_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_oog || load_res) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_oog) begin
      out_height <= '0;
      out_oog    <= 1'b1;
    end else if (load_res) begin
      out_height <= res;
      out_oog    <= 1'b0;
    end
  end

  assign res_out.valid         = out_valid;
  assign res_out.eroded_height = out_height;
  assign res_out.out_of_grid   = out_oog;

  // store is never written and read in one cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst) !(ram_we && ram_re))
    else $error("store write during neighborhood fetch");

  // a command leaves the queue only when one is there
  a_pop_has_head: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("queue popped while empty");

  // both slide pipelines stay in step
  a_units_aligned: assert property (@(posedge clk) disable iff (rst)
    (loss_tag.go == gain_tag.go) && (loss_tag.last == gain_tag.last))
    else $error("slide pipelines out of step");

  // walk never runs past the last neighbor
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == tes_pkg::BK_FETCH) |-> (idx <= tes_pkg::LAST_IDX))
    else $error("neighborhood walk overran");

  // a result is not overwritten while waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (load_oog || load_res) |-> (!out_valid || res_out.ready))
    else $error("pending result overwritten");

endmodule

// ===== hw/rtl/thermal_erosion_stencil_top.sv =====
// Thermal erosion stencil: a heightfield store with a one-pass talus slide read.
// Write commands store a cell's height and hardness; read commands return that
// cell's height after one thermal erosion pass over its 3x3 neighborhood. The
// front end checks each command against the grid in use and queues it; the back
// end executes it. A read inside the grid fetches the cell and its eight
// neighbors through the single read port of the cell store, then the five-stage
// slide pipelines drain and the result is registered. Commands are executed
// one at a time in order; the command in execution stays in the two-entry
// queue, so one more can wait behind it. The store has no reset, and reading a
// cell never written gives an undefined value.
module thermal_erosion_stencil_top #(
  parameter int MAX_COLS = tes_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tes_pkg::MAX_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  tes_in_if.sink                         item_in,
  tes_out_if.source                      result_out,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tes_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [tes_pkg::GRID_W-1:0] grid_width;
  logic [tes_pkg::GRID_W-1:0] grid_height;
  logic [tes_pkg::H_W-1:0]    talus;
  logic [tes_pkg::RATE_W-1:0] transfer_rate;
  tes_pkg::tes_reg_t          reg_sel;
  logic                       cfg_write;

  logic                push;
  logic                full;
  logic                q_valid;
  logic                pop;
  tes_pkg::tes_entry_t entry;
  tes_pkg::tes_entry_t head;

  // configuration registers
  assign pready    = 1'b1;
  assign reg_sel   = tes_pkg::tes_reg_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width    <= tes_pkg::GRID_WIDTH_RST;
      grid_height   <= tes_pkg::GRID_HEIGHT_RST;
      talus         <= tes_pkg::TALUS_RST;
      transfer_rate <= tes_pkg::TRANSFER_RATE_RST;
    end else if (cfg_write) begin
      case (reg_sel)
        tes_pkg::REG_GRID_WIDTH:    grid_width    <= pwdata[tes_pkg::GRID_W-1:0];
        tes_pkg::REG_GRID_HEIGHT:   grid_height   <= pwdata[tes_pkg::GRID_W-1:0];
        tes_pkg::REG_TALUS:         talus         <= pwdata[tes_pkg::H_W-1:0];
        tes_pkg::REG_TRANSFER_RATE: transfer_rate <= pwdata[tes_pkg::RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      tes_pkg::REG_GRID_WIDTH:    prdata = 32'(grid_width);
      tes_pkg::REG_GRID_HEIGHT:   prdata = 32'(grid_height);
      tes_pkg::REG_TALUS:         prdata = 32'(talus);
      tes_pkg::REG_TRANSFER_RATE: prdata = 32'(transfer_rate);
      default:                    prdata = '0;
    endcase
  end

  tes_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .cmd_in      (item_in),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .full        (full),
    .push        (push),
    .entry       (entry)
  );

  tes_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (entry),
    .full  (full),
    .valid (q_valid),
    .head  (head),
    .pop   (pop)
  );

  tes_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .head          (head),
    .pop           (pop),
    .talus         (talus),
    .transfer_rate (transfer_rate),
    .res_out       (result_out)
  );

endmodule

// ===== tb/tes_scoreboard.sv =====
// checker for the thermal erosion stencil: watches both channels and the register port
`timescale 1ns / 100ps

module tes_scoreboard
  import tes_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  tes_in_if                     item_mon,
  tes_out_if                    result_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int                    err_cnt,
  output int                    pending
);

  typedef struct {
    logic [H_W-1:0] height;
    logic           oog;
  } eroded_t;

  logic [H_W-1:0]    heights [0:65535];
  logic [HARD_W-1:0] hardness [0:65535];
  logic [GRID_W-1:0] cfg_width;
  logic [GRID_W-1:0] cfg_height;
  logic [H_W-1:0]    cfg_talus;
  logic [RATE_W-1:0] cfg_rate;
  eroded_t           eroded_q[$];

  assign pending = eroded_q.size();

  // material a giver of height hi and hardness hd sheds toward height lo
  function automatic longint unsigned slide_mass(logic [H_W-1:0] hi, logic [H_W-1:0] lo,
                                                 logic [HARD_W-1:0] hd);
    longint unsigned drop;
    if (hi <= lo) return 0;
    drop = hi - lo;
    if (drop <= cfg_talus) return 0;
    return (longint'(cfg_rate) * (drop - cfg_talus) * (1275 - 4 * longint'(hd)))
           / (64'd65536 * 64'd1275);
  endfunction

  // eroded height of one cell under the current settings
  function automatic eroded_t erode_cell(int c, int r);
    eroded_t         res;
    int              w, h, nx, ny;
    longint unsigned gain, loss, sum;
    logic [H_W-1:0]  self_h;
    gain = 0;
    loss = 0;
    w = (cfg_width == 0) ? 1 : (cfg_width > 256) ? 256 : int'(cfg_width);
    h = (cfg_height == 0) ? 1 : (cfg_height > 256) ? 256 : int'(cfg_height);
    if (c >= w || r >= h) begin
      res.height = '0;
      res.oog = 1'b1;
      return res;
    end
    self_h = heights[r * 256 + c];
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        nx = c + dx;
        ny = r + dy;
        if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 && nx < w && ny < h) begin
          loss += slide_mass(self_h, heights[ny * 256 + nx], hardness[r * 256 + c]);
          gain += slide_mass(heights[ny * 256 + nx], self_h, hardness[ny * 256 + nx]);
        end
      end
    end
    sum = self_h + gain;
    sum = (sum <= loss) ? 0 : sum - loss;
    res.height = (sum > HEIGHT_MAX) ? HEIGHT_MAX : sum[H_W-1:0];
    res.oog = 1'b0;
    return res;
  endfunction

  // register writes
  always @(posedge clk) begin
    if (rst) begin
      cfg_width  <= GRID_WIDTH_RST;
      cfg_height <= GRID_HEIGHT_RST;
      cfg_talus  <= TALUS_RST;
      cfg_rate   <= TRANSFER_RATE_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_GRID_WIDTH:    cfg_width  <= pwdata[GRID_W-1:0];
        REG_GRID_HEIGHT:   cfg_height <= pwdata[GRID_W-1:0];
        REG_TALUS:         cfg_talus  <= pwdata[H_W-1:0];
        REG_TRANSFER_RATE: cfg_rate   <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // command beats: writes update the store, reads queue an expectation
  always @(posedge clk) begin
    if (!rst && item_mon.valid && item_mon.ready) begin
      if (item_mon.command == CMD_WRITE) begin
        heights[item_mon.row * 256 + item_mon.col]  = item_mon.cell_height;
        hardness[item_mon.row * 256 + item_mon.col] = item_mon.cell_hardness;
      end else begin
        eroded_q.push_back(erode_cell(item_mon.col, item_mon.row));
      end
    end
  end

  // result beats against the oldest expectation
  initial err_cnt = 0;
  always @(posedge clk) begin
    eroded_t exp_r;
    if (!rst && result_mon.valid && result_mon.ready) begin
      if (eroded_q.size() == 0) begin
        $display("%0t: unexpected result height=%h oog=%b", $time,
                 result_mon.eroded_height, result_mon.out_of_grid);
        err_cnt++;
      end else begin
        exp_r = eroded_q.pop_front();
        if (exp_r.height !== result_mon.eroded_height) begin
          $display("%0t: eroded_height expected %h actual %h", $time, exp_r.height,
                   result_mon.eroded_height);
          err_cnt++;
        end
        if (exp_r.oog !== result_mon.out_of_grid) begin
          $display("%0t: out_of_grid expected %b actual %b", $time, exp_r.oog,
                   result_mon.out_of_grid);
          err_cnt++;
        end
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// stimulus and verdict for the thermal erosion stencil
`timescale 1ns / 100ps

module tb_top;
  import tes_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  logic                  clk;
  logic                  rst;
  logic                  psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata, prdata;
  int                    err_cnt, pending, idle_cnt, out_stall;
  bit                    quiet;
  bit                    written [0:65535];
  int                    grid_w, grid_h;
  logic [H_W-1:0]        level;
  int                    spread;
  int                    sent;

  tes_in_if  item_in ();
  tes_out_if result_out ();

  thermal_erosion_stencil_top u_top (
    .clk(clk), .rst(rst), .item_in(item_in.sink), .result_out(result_out.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  tes_scoreboard u_scoreboard (
    .clk(clk), .rst(rst), .item_mon(item_in), .result_mon(result_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready), .err_cnt(err_cnt), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side stalls
  always @(posedge clk) begin
    if (rst) begin
      result_out.ready <= 1'b0;
      out_stall <= 0;
    end else if (out_stall > 0) begin
      result_out.ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      result_out.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_stall <= pick_gap();
    end
  end

  // watchdog on beats
  always @(posedge clk) begin
    if (rst || (item_in.valid && item_in.ready) || (result_out.valid && result_out.ready))
      idle_cnt <= 0;
    else if (idle_cnt >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else
      idle_cnt <= idle_cnt + 1;
  end

  task automatic reg_write(tes_reg_t r, logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // settle the block, then load new settings
  task automatic set_config(logic [8:0] w, logic [8:0] h, logic [23:0] tal, logic [15:0] rate);
    item_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    reg_write(REG_GRID_WIDTH, w);
    reg_write(REG_GRID_HEIGHT, h);
    reg_write(REG_TALUS, tal);
    reg_write(REG_TRANSFER_RATE, rate);
    grid_w = (w == 0) ? 1 : (w > 256) ? 256 : int'(w);
    grid_h = (h == 0) ? 1 : (h > 256) ? 256 : int'(h);
  endtask

  task automatic send_beat(logic cmd, logic [7:0] c, logic [7:0] r, logic [23:0] hv,
                           logic [7:0] hd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_in.valid <= 1'b1;
    item_in.command <= cmd;
    item_in.col <= c;
    item_in.row <= r;
    item_in.cell_height <= hv;
    item_in.cell_hardness <= hd;
    do @(posedge clk); while (!item_in.ready);
    sent++;
    if (cmd == CMD_WRITE) written[r * 256 + c] = 1'b1;
  endtask

  function automatic logic [23:0] pick_height();
    int unsigned v;
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 24'hFFFFFF);
    v = level + $urandom_range(0, spread);
    return (v > 24'hFFFFFF) ? 24'hFFFFFF : v[23:0];
  endfunction

  task automatic store_cell(int c, int r);
    send_beat(CMD_WRITE, c, r, pick_height(), $urandom_range(0, 255));
  endtask

  // read a cell, loading any in-grid cell of its neighborhood never written
  task automatic read_cell(int c, int r);
    if (c < grid_w && r < grid_h) begin
      for (int y = r - 1; y <= r + 1; y++)
        for (int x = c - 1; x <= c + 1; x++)
          if (x >= 0 && y >= 0 && x < grid_w && y < grid_h && !written[y * 256 + x])
            store_cell(x, y);
    end
    send_beat(CMD_READ, c, r, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 255));
  endtask

  // mixed commands, mostly clustered in a small window of the grid, at least n beats in all
  task automatic random_phase(int n);
    int wc, wr, c, r, first;
    first = sent;
    wc = $urandom_range(0, grid_w - 1);
    wr = $urandom_range(0, grid_h - 1);
    while (sent - first < n) begin
      if ($urandom_range(0, 4) == 0) begin
        c = $urandom_range(0, 255);
        r = $urandom_range(0, 255);
      end else begin
        c = wc + $urandom_range(0, 7);
        r = wr + $urandom_range(0, 7);
        if (c >= grid_w) c = grid_w - 1;
        if (r >= grid_h) r = grid_h - 1;
      end
      if ($urandom_range(0, 99) < 35) store_cell(c, r);
      else read_cell(c, r);
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_in.valid = 1'b0;
    item_in.command = CMD_WRITE;
    item_in.col = '0;
    item_in.row = '0;
    item_in.cell_height = '0;
    item_in.cell_hardness = '0;
    result_out.ready = 1'b0;
    quiet = 1'b0;
    sent = 0;
    grid_w = 256;
    grid_h = 256;
    level = 24'h001000;
    spread = 2048;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: corners and field extremes under reset settings
    send_beat(CMD_WRITE, 0, 0, 24'h000000, 8'd0);
    send_beat(CMD_WRITE, 255, 255, 24'hFFFFFF, 8'd255);
    read_cell(0, 0);
    read_cell(255, 255);
    read_cell(254, 254);

    // directed: saturation with soft high neighbors, clamp with low neighbors
    set_config(256, 256, 0, 16'hFFFF);
    for (int y = 9; y <= 11; y++)
      for (int x = 9; x <= 11; x++)
        send_beat(CMD_WRITE, x, y, 24'hFFFFFF, 8'd0);
    send_beat(CMD_WRITE, 10, 10, 24'h000100, 8'd0);
    read_cell(10, 10);
    send_beat(CMD_WRITE, 10, 10, 24'hFFFFFF, 8'd0);
    send_beat(CMD_WRITE, 11, 11, 24'h000000, 8'd255);
    read_cell(10, 10);
    read_cell(11, 11);

    // directed: reads outside a small grid
    set_config(5, 3, 16, 30000);
    read_cell(5, 0);
    read_cell(0, 3);
    read_cell(4, 2);

    // random phases across settings, extremes included
    quiet = 1'b1;
    random_phase(80);
    quiet = 1'b0;
    set_config(0, 9'h1FF, 0, 16'hFFFF);
    random_phase(80);
    set_config(1, 1, 24'hFFFFFF, 0);
    random_phase(60);
    level = 24'hFFF000;
    spread = 4095;
    set_config(256, 256, 8, 16'hFFFF);
    random_phase(90);
    level = 24'h000000;
    spread = 1024;
    set_config(256, 256, 0, 50000);
    random_phase(90);
    for (int k = 0; k < 3; k++) begin
      level = $urandom_range(0, 24'hFFFFFF);
      spread = $urandom_range(16, 8192);
      set_config($urandom_range(0, 511), $urandom_range(0, 511),
                 $urandom_range(0, 3000), $urandom_range(0, 65535));
      random_phase(80);
    end
    item_in.valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tes_pkg.sv
hw/rtl/tes_channels.sv
hw/rtl/tes_ram.sv
hw/rtl/tes_queue.sv
hw/rtl/tes_front.sv
hw/rtl/tes_slide.sv
hw/rtl/tes_back.sv
hw/rtl/thermal_erosion_stencil_top.sv
tb/tes_scoreboard.sv
tb/tb_top.sv
